// File: rtl/cls_pkg.sv
`default_nettype none
package cls_pkg;

    localparam int unsigned POS_WIDTH_DEF = 32;

    localparam int unsigned TOL_W    = 16;
    localparam int unsigned GAIN_W   = 16;
    localparam int unsigned STEP_W   = 20;
    localparam int unsigned ITER_W   = 4;
    localparam int unsigned STATUS_W = 4;
    localparam int unsigned FUNC_W   = 2;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = STEP_W;

    // event codes
    localparam logic [FUNC_W-1:0] FUNC_START       = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SEG_DONE    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CORR_REPORT = 2'd2;

    // error codes (motion faults pass through unchanged)
    localparam logic [STATUS_W-1:0] ERR_CLEAR    = 4'd0;
    localparam logic [STATUS_W-1:0] ERR_BUSY     = 4'd1;
    localparam logic [STATUS_W-1:0] ERR_NOT_CONV = 4'd2;
    localparam logic [STATUS_W-1:0] STATUS_OK    = 4'd0;

    localparam logic [ITER_W-1:0] ITER_SAT = 4'd15;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TOL_X     = 3'd0,
        REG_TOL_Y     = 3'd1,
        REG_GAIN_NUM  = 3'd2,
        REG_GAIN_DEN  = 3'd3,
        REG_MAX_STEP  = 3'd4,
        REG_MAX_ITER  = 3'd5,
        REG_MIN_X     = 3'd6,
        REG_MIN_Y     = 3'd7
    } cfg_reg_t;

    localparam logic [TOL_W-1:0]  TOL_RST      = 16'd20;
    localparam logic [GAIN_W-1:0] GAIN_NUM_RST = 16'd1;
    localparam logic [GAIN_W-1:0] GAIN_DEN_RST = 16'd1;
    localparam logic [STEP_W-1:0] MAX_STEP_RST = 20'd2000;
    localparam logic [ITER_W-1:0] MAX_ITER_RST = 4'd6;
    localparam logic [TOL_W-1:0]  MIN_STEP_RST = 16'd10;

    typedef struct packed {
        logic [TOL_W-1:0]  tol_x;
        logic [TOL_W-1:0]  tol_y;
        logic [GAIN_W-1:0] gain_num;
        logic [GAIN_W-1:0] gain_den;
        logic [STEP_W-1:0] max_step;
        logic [ITER_W-1:0] max_iter;
        logic [TOL_W-1:0]  min_x;
        logic [TOL_W-1:0]  min_y;
    } cfg_t;

endpackage
`default_nettype wire

// File: rtl/cls_ifs.sv
`default_nettype none
interface cls_cmd_if #(
    parameter int unsigned POS_WIDTH = cls_pkg::POS_WIDTH_DEF
);
    logic                                valid;
    logic                                ready;
    logic [cls_pkg::FUNC_W-1:0]          func;
    logic signed [POS_WIDTH-1:0]         target_x;
    logic signed [POS_WIDTH-1:0]         target_y;
    logic signed [POS_WIDTH-1:0]         target_z;
    logic signed [POS_WIDTH-1:0]         target_phi;
    logic [cls_pkg::STATUS_W-1:0]        motion_status;
    logic signed [POS_WIDTH-1:0]         measured_x;
    logic signed [POS_WIDTH-1:0]         measured_y;
    logic signed [POS_WIDTH-1:0]         commanded_x;
    logic signed [POS_WIDTH-1:0]         commanded_y;

    modport source (
        output valid, func, target_x, target_y, target_z, target_phi,
               motion_status, measured_x, measured_y, commanded_x, commanded_y,
        input  ready
    );
    modport sink (
        input  valid, func, target_x, target_y, target_z, target_phi,
               motion_status, measured_x, measured_y, commanded_x, commanded_y,
        output ready
    );
endinterface

interface cls_rsp_if #(
    parameter int unsigned POS_WIDTH = cls_pkg::POS_WIDTH_DEF
);
    logic                                valid;
    logic                                ready;
    logic                                finished;
    logic [cls_pkg::STATUS_W-1:0]        error_code;
    logic                                move_valid;
    logic                                snap_valid;
    logic signed [POS_WIDTH-1:0]         move_x;
    logic signed [POS_WIDTH-1:0]         move_y;
    logic signed [POS_WIDTH-1:0]         move_z;
    logic signed [POS_WIDTH-1:0]         move_phi;

    modport source (
        output valid, finished, error_code, move_valid, snap_valid,
               move_x, move_y, move_z, move_phi,
        input  ready
    );
    modport sink (
        input  valid, finished, error_code, move_valid, snap_valid,
               move_x, move_y, move_z, move_phi,
        output ready
    );
endinterface
`default_nettype wire

// File: rtl/cls_cfg.sv
`default_nettype none
module cls_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             we,
    input  logic [cls_pkg::CFG_IDX_W-1:0]    index,
    input  logic [cls_pkg::CFG_DATA_W-1:0]   data,
    output cls_pkg::cfg_t                    cfg
);

    cls_pkg::cfg_t cfg_reg;

    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tol_x    <= cls_pkg::TOL_RST;
            cfg_reg.tol_y    <= cls_pkg::TOL_RST;
            cfg_reg.gain_num <= cls_pkg::GAIN_NUM_RST;
            cfg_reg.gain_den <= cls_pkg::GAIN_DEN_RST;
            cfg_reg.max_step <= cls_pkg::MAX_STEP_RST;
            cfg_reg.max_iter <= cls_pkg::MAX_ITER_RST;
            cfg_reg.min_x    <= cls_pkg::MIN_STEP_RST;
            cfg_reg.min_y    <= cls_pkg::MIN_STEP_RST;
        end
        else if (we)
        begin
            unique case (cls_pkg::cfg_reg_t'(index))
                cls_pkg::REG_TOL_X:    cfg_reg.tol_x    <= data[cls_pkg::TOL_W-1:0];
                cls_pkg::REG_TOL_Y:    cfg_reg.tol_y    <= data[cls_pkg::TOL_W-1:0];
                cls_pkg::REG_GAIN_NUM: cfg_reg.gain_num <= data[cls_pkg::GAIN_W-1:0];
                cls_pkg::REG_GAIN_DEN: cfg_reg.gain_den <= data[cls_pkg::GAIN_W-1:0];
                cls_pkg::REG_MAX_STEP: cfg_reg.max_step <= data[cls_pkg::STEP_W-1:0];
                cls_pkg::REG_MAX_ITER: cfg_reg.max_iter <= data[cls_pkg::ITER_W-1:0];
                cls_pkg::REG_MIN_X:    cfg_reg.min_x    <= data[cls_pkg::TOL_W-1:0];
                cls_pkg::REG_MIN_Y:    cfg_reg.min_y    <= data[cls_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: rtl/cls_div.sv
`default_nettype none
module cls_div #(
    parameter int unsigned DW = 48,
    parameter int unsigned VW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int unsigned CNTW = (DW > 1) ? $clog2(DW) : 1;

    logic            busy_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [DW-1:0]   quo_reg;
    logic [VW-1:0]   rem_reg;

    logic [VW:0]     rem_sh;
    logic [VW:0]     rem_sub;
    logic            fits;

    // restoring step: one quotient bit per cycle, MSB first
    assign rem_sh  = {rem_reg, quo_reg[DW-1]};
    assign fits    = (rem_sh >= {1'b0, divisor});
    assign rem_sub = fits ? (rem_sh - {1'b0, divisor}) : rem_sh;

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(DW - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DW-2:0], fits};
            rem_reg <= rem_sub[VW-1:0];
        end
    end

endmodule
`default_nettype wire

// File: rtl/closed_loop_move_sequencer_top.sv
// Closed-loop move sequencer.
// Input channel cmd carries one event word (start, segment done, correction
// start report); output channel rsp returns exactly one result word per
// event. Both use valid/ready; a word moves when both are high.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, since the block itself does not enforce it.
// Sequence: an event that needs no correction move (start, report, refused or
// idle event, snap, fault or not-converged finish) goes through S_EVAL and
// S_DONE, then loads the output register that raises rsp.valid. A segment-done
// event that needs a correction runs both axes through one multiplier and one
// shared bit-serial divider of POS_WIDTH+16 steps, in S_LOAD, S_DIV and S_FIX
// per axis, x then y, before S_DONE; a zero gain denominator skips S_DIV.
// cmd.ready is high only in S_IDLE, so one event is handled at a time.
// The output register holds a finished word until rsp.ready; the next event
// is accepted while it waits, and its result is held back until the output
// register frees up.
// Reset clears the job state and restores the register defaults.
`default_nettype none
module closed_loop_move_sequencer_top #(
    parameter int unsigned POS_WIDTH = cls_pkg::POS_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [cls_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cls_pkg::CFG_DATA_W-1:0]   cfg_data,
    cls_cmd_if.sink                          cmd,
    cls_rsp_if.source                        rsp
);

    localparam int unsigned W  = POS_WIDTH;
    localparam int unsigned DW = POS_WIDTH + cls_pkg::GAIN_W;
    localparam int unsigned SW = cls_pkg::STEP_W;
    localparam int unsigned CW = (POS_WIDTH > SW) ? POS_WIDTH : SW;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EVAL = 6'b000010,
        S_LOAD = 6'b000100,
        S_DIV  = 6'b001000,
        S_FIX  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    cls_pkg::cfg_t cfg;

    // job state
    logic                          job_active_reg;
    logic [cls_pkg::STATUS_W-1:0]  last_error_reg;
    logic [cls_pkg::ITER_W-1:0]    iter_reg;
    logic [W-1:0]                  goal_x_reg, goal_y_reg, goal_z_reg, goal_phi_reg;
    logic                          axis_reg;
    logic                          rsp_valid_reg;

    // latched event
    logic [cls_pkg::FUNC_W-1:0]    func_reg;
    logic [cls_pkg::STATUS_W-1:0]  status_reg;
    logic [W-1:0]                  tgt_x_reg, tgt_y_reg, tgt_z_reg, tgt_phi_reg;
    logic [W-1:0]                  meas_x_reg, meas_y_reg, cmdp_x_reg, cmdp_y_reg;

    // per-axis correction operands
    logic [W-1:0]                  mag_x_reg, mag_y_reg;
    logic                          neg_x_reg, neg_y_reg, out_x_reg, out_y_reg;
    logic [DW-1:0]                 q_reg;

    // staged and output result
    logic                          res_fin_reg, res_mv_reg, res_snap_reg;
    logic [cls_pkg::STATUS_W-1:0]  res_err_reg;
    logic [W-1:0]                  res_x_reg, res_y_reg, res_z_reg, res_phi_reg;
    logic                          o_fin_reg, o_mv_reg, o_snap_reg;
    logic [cls_pkg::STATUS_W-1:0]  o_err_reg;
    logic [W-1:0]                  o_x_reg, o_y_reg, o_z_reg, o_phi_reg;

    cls_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    // position error against the goal
    logic [W-1:0] err_x, err_y, mag_x, mag_y;
    logic         neg_x, neg_y, within_x, within_y;

    assign err_x    = goal_x_reg - meas_x_reg;
    assign err_y    = goal_y_reg - meas_y_reg;
    assign neg_x    = err_x[W-1];
    assign neg_y    = err_y[W-1];
    assign mag_x    = neg_x ? (W'(0) - err_x) : err_x;
    assign mag_y    = neg_y ? (W'(0) - err_y) : err_y;
    assign within_x = (mag_x <= W'(cfg.tol_x));
    assign within_y = (mag_y <= W'(cfg.tol_y));

    // event decode
    logic                          ev_fin, ev_snap, ev_mv, ev_active, ev_load_goal;
    logic [cls_pkg::STATUS_W-1:0]  ev_err, ev_last;
    logic [cls_pkg::ITER_W-1:0]    ev_iter;

    always_comb
    begin
        ev_fin       = 1'b0;
        ev_err       = cls_pkg::ERR_CLEAR;
        ev_snap      = 1'b0;
        ev_mv        = 1'b0;
        ev_active    = job_active_reg;
        ev_last      = last_error_reg;
        ev_iter      = iter_reg;
        ev_load_goal = 1'b0;
        if (func_reg == cls_pkg::FUNC_START)
        begin
            if (job_active_reg)
            begin
                ev_err = cls_pkg::ERR_BUSY;
            end
            else
            begin
                ev_load_goal = 1'b1;
                ev_iter      = '0;
                ev_last      = status_reg;
                if (status_reg != cls_pkg::STATUS_OK)
                begin
                    ev_fin = 1'b1;
                    ev_err = status_reg;
                end
                else
                begin
                    ev_active = 1'b1;
                end
            end
        end
        else if (!job_active_reg)
        begin
            ev_fin = 1'b1;
            ev_err = last_error_reg;
        end
        else
        begin
            unique case (func_reg)
                cls_pkg::FUNC_SEG_DONE:
                begin
                    if (status_reg != cls_pkg::STATUS_OK)
                    begin
                        ev_last   = status_reg;
                        ev_active = 1'b0;
                        ev_fin    = 1'b1;
                        ev_err    = status_reg;
                    end
                    else if (within_x && within_y)
                    begin
                        ev_last   = cls_pkg::ERR_CLEAR;
                        ev_active = 1'b0;
                        ev_fin    = 1'b1;
                        ev_snap   = 1'b1;
                    end
                    else if (iter_reg >= cfg.max_iter)
                    begin
                        ev_last   = cls_pkg::ERR_NOT_CONV;
                        ev_active = 1'b0;
                        ev_fin    = 1'b1;
                        ev_err    = cls_pkg::ERR_NOT_CONV;
                    end
                    else
                    begin
                        ev_mv = 1'b1;
                    end
                end
                cls_pkg::FUNC_CORR_REPORT:
                begin
                    if (status_reg != cls_pkg::STATUS_OK)
                    begin
                        ev_last   = status_reg;
                        ev_active = 1'b0;
                        ev_fin    = 1'b1;
                        ev_err    = status_reg;
                    end
                    else if (iter_reg < cls_pkg::ITER_SAT)
                    begin
                        ev_iter = iter_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // shared multiply and divide for the selected axis
    logic [W-1:0]  sel_mag, sel_cmdp, c_pos, new_pos;
    logic          sel_neg, sel_out;
    logic [cls_pkg::TOL_W-1:0] sel_min;
    logic [DW-1:0] prod, dividend, div_quo;
    logic          div_start, div_done;
    logic [SW-1:0] q_clamp, q_fin;
    logic [CW-1:0] c_wide;

    assign sel_mag  = axis_reg ? mag_y_reg  : mag_x_reg;
    assign sel_neg  = axis_reg ? neg_y_reg  : neg_x_reg;
    assign sel_out  = axis_reg ? out_y_reg  : out_x_reg;
    assign sel_cmdp = axis_reg ? cmdp_y_reg : cmdp_x_reg;
    assign sel_min  = axis_reg ? cfg.min_y  : cfg.min_x;

    assign prod     = {{cls_pkg::GAIN_W{1'b0}}, sel_mag} * {{W{1'b0}}, cfg.gain_num};
    assign dividend = prod + DW'(cfg.gain_den >> 1);

    assign div_start = (state_reg == S_LOAD) && (cfg.gain_den != '0);

    cls_div #(
        .DW (DW),
        .VW (cls_pkg::GAIN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (cfg.gain_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    // clamp to max step, then raise to the minimum step while outside tolerance
    assign q_clamp = (q_reg > DW'(cfg.max_step)) ? cfg.max_step : q_reg[SW-1:0];
    assign q_fin   = (sel_out && (q_clamp < SW'(sel_min))) ? SW'(sel_min) : q_clamp;
    assign c_wide  = CW'(q_fin);
    assign c_pos   = c_wide[W-1:0];
    assign new_pos = sel_neg ? (sel_cmdp - c_pos) : (sel_cmdp + c_pos);

    logic need_corr, out_free;

    assign need_corr = ev_mv;
    assign out_free  = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (cmd.valid) state_next = S_EVAL;
            S_EVAL: state_next = need_corr ? S_LOAD : S_DONE;
            S_LOAD: state_next = (cfg.gain_den == '0) ? S_FIX : S_DIV;
            S_DIV:  if (div_done) state_next = S_FIX;
            S_FIX:  state_next = axis_reg ? S_DONE : S_LOAD;
            S_DONE: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            job_active_reg <= 1'b0;
            last_error_reg <= cls_pkg::ERR_CLEAR;
            iter_reg       <= '0;
            goal_x_reg     <= '0;
            goal_y_reg     <= '0;
            goal_z_reg     <= '0;
            goal_phi_reg   <= '0;
            axis_reg       <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_EVAL)
            begin
                job_active_reg <= ev_active;
                last_error_reg <= ev_last;
                iter_reg       <= ev_iter;
                axis_reg       <= 1'b0;
                if (ev_load_goal)
                begin
                    goal_x_reg   <= tgt_x_reg;
                    goal_y_reg   <= tgt_y_reg;
                    goal_z_reg   <= tgt_z_reg;
                    goal_phi_reg <= tgt_phi_reg;
                end
            end
            if (state_reg == S_FIX)
            begin
                axis_reg <= 1'b1;
            end
            // load a new word, or drop the one taken by the receiver
            if ((state_reg == S_DONE) && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            func_reg    <= cmd.func;
            status_reg  <= cmd.motion_status;
            tgt_x_reg   <= cmd.target_x;
            tgt_y_reg   <= cmd.target_y;
            tgt_z_reg   <= cmd.target_z;
            tgt_phi_reg <= cmd.target_phi;
            meas_x_reg  <= cmd.measured_x;
            meas_y_reg  <= cmd.measured_y;
            cmdp_x_reg  <= cmd.commanded_x;
            cmdp_y_reg  <= cmd.commanded_y;
        end
        if (state_reg == S_EVAL)
        begin
            mag_x_reg    <= mag_x;
            mag_y_reg    <= mag_y;
            neg_x_reg    <= neg_x;
            neg_y_reg    <= neg_y;
            out_x_reg    <= !within_x;
            out_y_reg    <= !within_y;
            res_fin_reg  <= ev_fin;
            res_err_reg  <= ev_err;
            res_mv_reg   <= ev_mv;
            res_snap_reg <= ev_snap;
            res_x_reg    <= ev_snap ? goal_x_reg : '0;
            res_y_reg    <= ev_snap ? goal_y_reg : '0;
            res_z_reg    <= (ev_snap || ev_mv) ? goal_z_reg   : '0;
            res_phi_reg  <= (ev_snap || ev_mv) ? goal_phi_reg : '0;
        end
        if ((state_reg == S_LOAD) && (cfg.gain_den == '0))
        begin
            q_reg <= '0;
        end
        if ((state_reg == S_DIV) && div_done)
        begin
            q_reg <= div_quo;
        end
        if (state_reg == S_FIX)
        begin
            if (axis_reg)
            begin
                res_y_reg <= new_pos;
            end
            else
            begin
                res_x_reg <= new_pos;
            end
        end
        if ((state_reg == S_DONE) && out_free)
        begin
            o_fin_reg  <= res_fin_reg;
            o_err_reg  <= res_err_reg;
            o_mv_reg   <= res_mv_reg;
            o_snap_reg <= res_snap_reg;
            o_x_reg    <= res_x_reg;
            o_y_reg    <= res_y_reg;
            o_z_reg    <= res_z_reg;
            o_phi_reg  <= res_phi_reg;
        end
    end

    assign cmd.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.finished   = o_fin_reg;
    assign rsp.error_code = o_err_reg;
    assign rsp.move_valid = o_mv_reg;
    assign rsp.snap_valid = o_snap_reg;
    assign rsp.move_x     = o_x_reg;
    assign rsp.move_y     = o_y_reg;
    assign rsp.move_z     = o_z_reg;
    assign rsp.move_phi   = o_phi_reg;

`ifndef ASSERT_OFF
    a_move_or_snap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.move_valid && rsp.snap_valid))
        else $error("move and snap requested in one word");

    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide state");

    a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> (state_reg == S_EVAL))
        else $error("accepted word not evaluated");

    a_corr_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> job_active_reg)
        else $error("correction running without an active job");
`endif

endmodule
`default_nettype wire
